>>> hdl/assert_macros.svh
// Assertion helpers for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge outside of reset.
`define CDL_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that cond at one edge is followed by result at the next edge.
`define CDL_ASSERT_NEXT(name, clk, rst_n, cond, result, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (result)) \
		else $error(msg);

`endif

>>> hdl/cdl_pkg.sv
package cdl_pkg;

	localparam int PREFIX_CHARS_DEF = 8;
	localparam int TEXT_PREFIX_W = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	typedef enum logic [3:0] {
		TK_END = 4'd0,
		TK_LPAREN = 4'd1,
		TK_RPAREN = 4'd2,
		TK_LBRACKET = 4'd3,
		TK_RBRACKET = 4'd4,
		TK_COMMA = 4'd5,
		TK_STAR = 4'd6,
		TK_INTEGER = 4'd7,
		TK_IDENT = 4'd8,
		TK_VOID = 4'd9,
		TK_CHAR = 4'd10,
		TK_SHORT = 4'd11,
		TK_INT = 4'd12,
		TK_LONG = 4'd13,
		TK_FLOAT = 4'd14,
		TK_DOUBLE = 4'd15
	} token_kind_t;

	typedef struct packed {
		token_kind_t kind;
		logic [31:0] int_value;
		logic int_overflow;
		logic [7:0] text_length;
		logic [TEXT_PREFIX_W-1:0] text_prefix;
		logic text_truncated;
		logic last;
	} token_t;

	// Number of tokens produced by the accepted item: 0, 1 or 2.
	typedef struct packed {
		logic [1:0] count;
	} push_t;

	typedef struct packed {
		logic ready;
		logic valid;
		logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
	} queue_stat_t;

endpackage

>>> hdl/cdl_lex_engine.sv
module cdl_lex_engine #(
	parameter int PREFIX_CHARS = cdl_pkg::PREFIX_CHARS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    char_in,
	output cdl_pkg::push_t  push,
	output cdl_pkg::token_t tok_a,
	output cdl_pkg::token_t tok_b
);
	import cdl_pkg::*;

	localparam int BUF_W = PREFIX_CHARS * 8;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_INT = 2'd1,
		MODE_IDENT = 2'd2
	} lex_mode_t;

	lex_mode_t mode_q, mode_d;
	logic [BUF_W-1:0] text_q, text_d;
	logic [7:0] count_q, count_d;
	logic [31:0] number_q, number_d;
	logic overflow_q, overflow_d;

	logic is_digit, is_alpha, in_int, in_ident, extend, closing;
	logic punct_hit;
	token_kind_t punct_kind;
	logic [35:0] acc_x10;
	token_t closed_tok, punct_tok;

	// Identifier text is zero beyond its length, so a whole-word compare suffices.
	function automatic token_kind_t keyword_kind(input logic [TEXT_PREFIX_W-1:0] txt,
	                                             input logic [7:0] len);
		token_kind_t kind;
		kind = TK_IDENT;
		if (len == 8'd4 && txt == 64'h0000_0000_6469_6F76) kind = TK_VOID;
		if (len == 8'd4 && txt == 64'h0000_0000_7261_6863) kind = TK_CHAR;
		if (len == 8'd5 && txt == 64'h0000_0074_726F_6873) kind = TK_SHORT;
		if (len == 8'd3 && txt == 64'h0000_0000_0074_6E69) kind = TK_INT;
		if (len == 8'd4 && txt == 64'h0000_0000_676E_6F6C) kind = TK_LONG;
		if (len == 8'd5 && txt == 64'h0000_0074_616F_6C66) kind = TK_FLOAT;
		if (len == 8'd6 && txt == 64'h0000_656C_6275_6F64) kind = TK_DOUBLE;
		return kind;
	endfunction

	assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
	assign is_alpha = ((char_in >= 8'h61) && (char_in <= 8'h7A)) ||
	                  ((char_in >= 8'h41) && (char_in <= 8'h5A)) ||
	                  (char_in == CH_UNDERSCORE);
	assign in_int = (mode_q == MODE_INT);
	assign in_ident = (mode_q == MODE_IDENT);
	assign extend = (in_int && is_digit) || (in_ident && (is_digit || is_alpha));
	assign closing = (in_int || in_ident) && !extend;

	assign acc_x10 = {1'b0, number_q, 3'b000} + {3'b000, number_q, 1'b0} +
	                 {32'd0, char_in[3:0]};

	always_comb begin
		punct_hit = 1'b1;
		unique case (char_in)
			CH_DOLLAR: punct_kind = TK_END;
			CH_LPAREN: punct_kind = TK_LPAREN;
			CH_RPAREN: punct_kind = TK_RPAREN;
			CH_LBRACKET: punct_kind = TK_LBRACKET;
			CH_RBRACKET: punct_kind = TK_RBRACKET;
			CH_COMMA: punct_kind = TK_COMMA;
			CH_STAR: punct_kind = TK_STAR;
			default: begin
				punct_kind = TK_END;
				punct_hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		closed_tok = '0;
		if (in_int) begin
			closed_tok.kind = TK_INTEGER;
			closed_tok.int_value = number_q;
			closed_tok.int_overflow = overflow_q;
		end else begin
			closed_tok.kind = keyword_kind(TEXT_PREFIX_W'(text_q), count_q);
			closed_tok.text_length = count_q;
			closed_tok.text_prefix = TEXT_PREFIX_W'(text_q);
			closed_tok.text_truncated = (count_q > 8'(PREFIX_CHARS));
		end
		punct_tok = '0;
		punct_tok.kind = punct_kind;
		punct_tok.last = 1'b1;
	end

	// A closing character can emit the closed token and then its own token.
	always_comb begin
		push.count = 2'd0;
		tok_a = punct_tok;
		tok_b = punct_tok;
		if (take && !extend) begin
			if (closing) begin
				tok_a = closed_tok;
				tok_a.last = !punct_hit;
				push.count = punct_hit ? 2'd2 : 2'd1;
			end else if (punct_hit) begin
				push.count = 2'd1;
			end
		end
	end

	always_comb begin
		mode_d = mode_q;
		text_d = text_q;
		count_d = count_q;
		number_d = number_q;
		overflow_d = overflow_q;
		if (extend && in_int) begin
			if (acc_x10[35:32] != 4'd0) begin
				number_d = '1;
				overflow_d = 1'b1;
			end else begin
				number_d = acc_x10[31:0];
			end
		end else if (extend) begin
			for (int i = 0; i < PREFIX_CHARS; i++) begin
				if (count_q == 8'(i)) text_d[i*8 +: 8] = char_in;
			end
			if (count_q != 8'hFF) count_d = count_q + 8'd1;
		end else begin
			mode_d = MODE_IDLE;
			text_d = '0;
			count_d = '0;
			number_d = '0;
			overflow_d = 1'b0;
			if (is_digit) begin
				mode_d = MODE_INT;
				number_d = {28'd0, char_in[3:0]};
			end else if (is_alpha) begin
				mode_d = MODE_IDENT;
				text_d = BUF_W'(char_in);
				count_d = 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			text_q <= '0;
			count_q <= '0;
			number_q <= '0;
			overflow_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			text_q <= text_d;
			count_q <= count_d;
			number_q <= number_d;
			overflow_q <= overflow_d;
		end
	end

endmodule

>>> hdl/cdl_out_queue.sv
module cdl_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  cdl_pkg::push_t    push,
	input  cdl_pkg::token_t   tok_a,
	input  cdl_pkg::token_t   tok_b,
	input  logic              pop,
	output cdl_pkg::token_t   head,
	output cdl_pkg::queue_stat_t stat
);
	import cdl_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	token_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q, tail_next;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign tail_next = ptr_inc(tail_q);
	assign head = entry_q[head_q];
	assign stat.valid = (count_q != '0);
	// Room for two tokens is kept so a closing character never stalls mid-item.
	assign stat.ready = (count_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign stat.count = count_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) entry_q[tail_q] <= tok_a;
		if (push.count == 2'd2) entry_q[tail_next] <= tok_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (pop) head_q <= ptr_inc(head_q);
			case (push.count)
				2'd1: tail_q <= tail_next;
				2'd2: tail_q <= ptr_inc(tail_next);
				default: tail_q <= tail_q;
			endcase
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

>>> hdl/c_declaration_lexer_core.sv
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | char_in
// output   | out_valid / out_ready| token_kind, int_value, int_overflow, text_length,
//          |                      | text_prefix, text_truncated, last
//
// One character is taken per cycle while in_ready is high; the lexer state updates
// at the accepting edge, which also writes its tokens into a four-entry queue.
// A character that closes a token and is itself punctuation yields two tokens, which
// are popped singly; in_ready drops only when fewer than two slots are free.
// Reset returns the lexer to idle with an empty queue.
`include "assert_macros.svh"

module c_declaration_lexer_core #(
	parameter int PREFIX_CHARS = cdl_pkg::PREFIX_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic [31:0] int_value,
	output logic        int_overflow,
	output logic [7:0]  text_length,
	output logic [63:0] text_prefix,
	output logic        text_truncated,
	output logic        last
);
	import cdl_pkg::*;

	logic take, pop;
	push_t push;
	token_t tok_a, tok_b, head;
	queue_stat_t stat;

	assign in_ready = stat.ready;
	assign take = in_valid && stat.ready;
	assign out_valid = stat.valid;
	assign pop = stat.valid && out_ready;

	cdl_lex_engine #(
		.PREFIX_CHARS(PREFIX_CHARS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.char_in(char_in),
		.push(push),
		.tok_a(tok_a),
		.tok_b(tok_b)
	);

	cdl_out_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.tok_a(tok_a),
		.tok_b(tok_b),
		.pop(pop),
		.head(head),
		.stat(stat)
	);

	assign token_kind = head.kind;
	assign int_value = head.int_value;
	assign int_overflow = head.int_overflow;
	assign text_length = head.text_length;
	assign text_prefix = head.text_prefix;
	assign text_truncated = head.text_truncated;
	assign last = head.last;

	`CDL_ASSERT(a_no_push_idle, clk, arst_n, take || push.count == 2'd0, "token pushed without an item")
	`CDL_ASSERT(a_queue_bound, clk, arst_n, stat.count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue overrun")
	`CDL_ASSERT(a_end_is_last, clk, arst_n, !out_valid || token_kind != TK_END || last, "end token not last")
	`CDL_ASSERT_NEXT(a_push_shows, clk, arst_n, push.count != 2'd0, out_valid, "pushed token not visible")

endmodule
